/* src/scs_pkg.sv */
package scs_pkg;

    localparam int DATA_W          = 12;
    localparam int COUNT_W         = 13;
    localparam int SLOPE_W         = 18;
    localparam int OFFSET_W        = 12;
    localparam int MV_W            = 16;
    localparam int KEPT_W          = 13;
    localparam int MAX_SAMPLES_DEF = 4096;

    // q8 values of 12-bit data and their squares
    localparam int Q8_W  = DATA_W + 8;
    localparam int VAR_W = 2 * Q8_W;
    localparam int PROD_W = SLOPE_W + Q8_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] REG_CALIB_SLOPE  = 2'd1;
    localparam logic [1:0] REG_CALIB_OFFSET = 2'd2;

    localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 13'd64;

    typedef struct packed {
        logic job_valid;
        logic wr_en;
    } front_ctl_t;

    typedef struct packed {
        logic job_take;
        logic pass_done;
    } back_ctl_t;

endpackage

/* src/scs_cfg.sv */
module scs_cfg
    import scs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COUNT_W-1:0]    sample_count,
    output logic [SLOPE_W-1:0]    calib_slope,
    output logic [OFFSET_W-1:0]   calib_offset
);

    logic [COUNT_W-1:0]  count_reg;
    logic [SLOPE_W-1:0]  slope_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                wr;
    logic [1:0]          idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= SAMPLE_COUNT_RST;
            slope_reg  <= '0;
            offset_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_SAMPLE_COUNT: count_reg  <= pwdata[COUNT_W-1:0];
                REG_CALIB_SLOPE:  slope_reg  <= pwdata[SLOPE_W-1:0];
                REG_CALIB_OFFSET: offset_reg <= pwdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SAMPLE_COUNT: prdata = APB_DATA_W'(count_reg);
            REG_CALIB_SLOPE:  prdata = APB_DATA_W'(slope_reg);
            REG_CALIB_OFFSET: prdata = APB_DATA_W'(offset_reg);
            default:          prdata = '0;
        endcase
    end

    assign sample_count = count_reg;
    assign calib_slope  = slope_reg;
    assign calib_offset = offset_reg;

endmodule

/* src/scs_front.sv */
module scs_front
    import scs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int CW = $clog2(MAX_SAMPLES + 1),
    parameter int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    parameter int SW = DATA_W + CW,
    parameter int QW = 2 * DATA_W + CW
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [DATA_W-1:0] raw_sample,
    input  logic [COUNT_W-1:0] sample_count,
    output front_ctl_t        fctl,
    input  back_ctl_t         bctl,
    output logic [AW-1:0]     wr_addr,
    output logic [DATA_W-1:0] wr_data,
    output logic [CW-1:0]     job_n,
    output logic [SW-1:0]     job_sum,
    output logic [QW-1:0]     job_sq
);

    logic [CW-1:0] fill_reg;
    logic [SW-1:0] sum_reg;
    logic [QW-1:0] sq_reg;
    logic          busy_reg;
    logic          job_valid_reg;
    logic [CW-1:0] jn_reg;
    logic [SW-1:0] js_reg;
    logic [QW-1:0] jq_reg;

    logic          acc;
    logic [CW-1:0] len;
    logic [CW-1:0] n_new;
    logic [SW-1:0] sum_new;
    logic [QW-1:0] sq_new;
    logic          last;

    always_comb
    begin
        if (sample_count == '0)
            len = CW'(1);
        else if (32'(sample_count) > 32'(MAX_SAMPLES))
            len = CW'(MAX_SAMPLES);
        else
            len = CW'(sample_count);
    end

    assign full    = busy_reg;
    assign acc     = push && !busy_reg;
    assign n_new   = fill_reg + CW'(1);
    assign sum_new = sum_reg + SW'(raw_sample);
    assign sq_new  = sq_reg + QW'(raw_sample) * QW'(raw_sample);
    // a count written below the fill level ends the burst on the next sample
    assign last    = (32'(n_new) >= 32'(len));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            busy_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (bctl.job_take)
                job_valid_reg <= 1'b0;
            if (bctl.pass_done)
                busy_reg <= 1'b0;
            if (acc)
            begin
                if (last)
                begin
                    fill_reg      <= '0;
                    sum_reg       <= '0;
                    sq_reg        <= '0;
                    busy_reg      <= 1'b1;
                    job_valid_reg <= 1'b1;
                end
                else
                begin
                    fill_reg <= n_new;
                    sum_reg  <= sum_new;
                    sq_reg   <= sq_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && last)
        begin
            jn_reg <= n_new;
            js_reg <= sum_new;
            jq_reg <= sq_new;
        end
    end

    assign fctl.job_valid = job_valid_reg;
    assign fctl.wr_en     = acc;
    assign wr_addr        = fill_reg[AW-1:0];
    assign wr_data        = raw_sample;
    assign job_n          = jn_reg;
    assign job_sum        = js_reg;
    assign job_sq         = jq_reg;

endmodule

/* src/scs_div.sv */
module scs_div #(
    parameter int DVW = 66,
    parameter int DSW = 26
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           done,
    output logic [DVW-1:0] quotient
);

    localparam int NW = $clog2(DVW + 1);

    logic [DVW-1:0] quo_reg;
    logic [DSW-1:0] rem_reg;
    logic [DSW-1:0] div_reg;
    logic [NW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [DSW:0]   trial;
    logic           ge;
    logic [DSW-1:0] rem_next;

    // restoring division, one quotient bit a cycle
    assign trial    = {rem_reg, quo_reg[DVW-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign rem_next = ge ? DSW'(trial - {1'b0, div_reg}) : DSW'(trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(DVW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* src/scs_back.sv */
module scs_back
    import scs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int CW = $clog2(MAX_SAMPLES + 1),
    parameter int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
    parameter int SW = DATA_W + CW,
    parameter int QW = 2 * DATA_W + CW
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  front_ctl_t          fctl,
    output back_ctl_t           bctl,
    input  logic [AW-1:0]       wr_addr,
    input  logic [DATA_W-1:0]   wr_data,
    input  logic [CW-1:0]       job_n,
    input  logic [SW-1:0]       job_sum,
    input  logic [QW-1:0]       job_sq,
    input  logic [SLOPE_W-1:0]  calib_slope,
    input  logic [OFFSET_W-1:0] calib_offset,
    output logic                empty,
    input  logic                pop,
    output logic [MV_W-1:0]     millivolts,
    output logic [KEPT_W-1:0]   kept_count
);

    localparam int DVW = 2 * SW + 16;
    localparam int DSW = 2 * CW;
    localparam int CAL_W = PROD_W + 2;
    localparam int T_W = CAL_W - 16 + 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_DV   = 4'd2;
    localparam logic [3:0] ST_DT1  = 4'd3;
    localparam logic [3:0] ST_DT2  = 4'd4;
    localparam logic [3:0] ST_PASS = 4'd5;
    localparam logic [3:0] ST_DM   = 4'd6;
    localparam logic [3:0] ST_CAL1 = 4'd7;
    localparam logic [3:0] ST_CAL2 = 4'd8;

    logic [DATA_W-1:0] mem [MAX_SAMPLES];

    logic [3:0]        state_reg;
    logic              dstart_reg;
    logic [CW-1:0]     n_reg;
    logic [SW-1:0]     s_reg;
    logic [QW-1:0]     q_reg;
    logic [2*SW-1:0]   s2_reg;
    logic [DSW-1:0]    nn_reg;
    logic [Q8_W-1:0]   v_reg;
    logic [DVW-1:0]    t1_reg;
    logic [VAR_W-1:0]  var_reg;
    logic [CW-1:0]     rd_cnt_reg;
    logic              p1_reg;
    logic              p2_reg;
    logic              p3_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] x2_reg;
    logic [DATA_W-1:0] x3_reg;
    logic [Q8_W-1:0]   d_reg;
    logic [VAR_W-1:0]  sq_reg;
    logic [SW-1:0]     ksum_reg;
    logic [CW-1:0]     kept_reg;
    logic [Q8_W-1:0]   m_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              ovalid_reg;
    logic [MV_W-1:0]   mv_reg;
    logic [KEPT_W-1:0] kc_reg;

    logic              in_div;
    logic              div_start;
    logic              div_done;
    logic [DVW-1:0]    dividend;
    logic [DSW-1:0]    divisor;
    logic [DVW-1:0]    quo;
    logic              issue;
    logic              pass_done;
    logic [Q8_W-1:0]   x256;
    logic [CAL_W-1:0]  cal_sum;
    logic [T_W-1:0]    t_val;
    logic [MV_W-1:0]   mv_sat;
    logic              out_load;

    assign in_div = (state_reg == ST_DV) || (state_reg == ST_DT1) ||
                    (state_reg == ST_DT2) || (state_reg == ST_DM);
    assign div_start = in_div && !dstart_reg;

    always_comb
    begin
        case (state_reg)
            ST_DV:
            begin
                dividend = DVW'(s_reg) << 8;
                divisor  = DSW'(n_reg);
            end
            ST_DT1:
            begin
                dividend = DVW'(q_reg) << 16;
                divisor  = DSW'(n_reg);
            end
            ST_DT2:
            begin
                dividend = DVW'(s2_reg) << 16;
                divisor  = nn_reg;
            end
            default:
            begin
                dividend = DVW'(ksum_reg) << 8;
                divisor  = DSW'(kept_reg);
            end
        endcase
    end

    scs_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quo)
    );

    assign issue     = (state_reg == ST_PASS) && (rd_cnt_reg != n_reg);
    assign pass_done = (state_reg == ST_PASS) && (rd_cnt_reg == n_reg) &&
                       !p1_reg && !p2_reg && !p3_reg;
    assign x256      = {rdata_reg, 8'd0};

    assign cal_sum = CAL_W'(prod_reg) + CAL_W'(24'h800000)
                   + (CAL_W'(calib_offset) << 24);
    assign t_val   = T_W'(cal_sum >> 16) + T_W'(128);
    assign mv_sat  = ((t_val >> 8) > T_W'(16'hFFFF)) ? 16'hFFFF : MV_W'(t_val >> 8);
    assign out_load = (state_reg == ST_CAL2) && (!ovalid_reg || pop);

    always_ff @(posedge clk)
    begin
        if (fctl.wr_en)
            mem[wr_addr] <= wr_data;
        if (issue)
            rdata_reg <= mem[rd_cnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dstart_reg <= 1'b0;
            rd_cnt_reg <= '0;
            p1_reg     <= 1'b0;
            p2_reg     <= 1'b0;
            p3_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= issue;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            if (issue)
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            if (div_start)
                dstart_reg <= 1'b1;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (pop)
                ovalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                    if (fctl.job_valid)
                        state_reg <= ST_MUL;
                ST_MUL:
                    state_reg <= ST_DV;
                ST_DV:
                    if (div_done)
                    begin
                        dstart_reg <= 1'b0;
                        state_reg  <= ST_DT1;
                    end
                ST_DT1:
                    if (div_done)
                    begin
                        dstart_reg <= 1'b0;
                        state_reg  <= ST_DT2;
                    end
                ST_DT2:
                    if (div_done)
                    begin
                        dstart_reg <= 1'b0;
                        rd_cnt_reg <= '0;
                        state_reg  <= ST_PASS;
                    end
                ST_PASS:
                    if (pass_done)
                        state_reg <= (kept_reg == '0) ? ST_CAL1 : ST_DM;
                ST_DM:
                    if (div_done)
                    begin
                        dstart_reg <= 1'b0;
                        state_reg  <= ST_CAL1;
                    end
                ST_CAL1:
                    state_reg <= ST_CAL2;
                ST_CAL2:
                    if (out_load)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && fctl.job_valid)
        begin
            n_reg <= job_n;
            s_reg <= job_sum;
            q_reg <= job_sq;
        end
        if (state_reg == ST_MUL)
        begin
            s2_reg <= s_reg * s_reg;
            nn_reg <= n_reg * n_reg;
        end
        if (div_done)
        begin
            case (state_reg)
                ST_DV:   v_reg   <= quo[Q8_W-1:0];
                ST_DT1:  t1_reg  <= quo;
                ST_DT2:  var_reg <= VAR_W'(t1_reg - quo);
                default: m_reg   <= quo[Q8_W-1:0];
            endcase
        end
        if (state_reg == ST_DT2 && div_done)
        begin
            ksum_reg <= '0;
            kept_reg <= '0;
        end
        if (state_reg == ST_PASS && pass_done && kept_reg == '0)
            m_reg <= '0;

        // clipping pipeline: read, deviation, square, compare
        if (p1_reg)
        begin
            d_reg  <= (x256 >= v_reg) ? x256 - v_reg : v_reg - x256;
            x2_reg <= rdata_reg;
        end
        if (p2_reg)
        begin
            sq_reg <= d_reg * d_reg;
            x3_reg <= x2_reg;
        end
        if (p3_reg && sq_reg <= var_reg)
        begin
            ksum_reg <= ksum_reg + SW'(x3_reg);
            kept_reg <= kept_reg + CW'(1);
        end

        if (state_reg == ST_CAL1)
            prod_reg <= calib_slope * m_reg;
        if (out_load)
        begin
            mv_reg <= mv_sat;
            kc_reg <= KEPT_W'(kept_reg);
        end
    end

    assign bctl.job_take  = (state_reg == ST_IDLE) && fctl.job_valid;
    assign bctl.pass_done = pass_done;

    assign empty      = !ovalid_reg;
    assign millivolts = mv_reg;
    assign kept_count = kc_reg;

    a_no_write_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        !(fctl.wr_en && state_reg == ST_PASS))
        else $error("sample store written during clipping pass");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !pop) |-> !out_load)
        else $error("waiting result overwritten");

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pass_done |-> (kept_reg <= n_reg))
        else $error("kept count exceeds burst length");

    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (32'(rd_cnt_reg) < 32'(MAX_SAMPLES)))
        else $error("read beyond sample store");

endmodule

/* src/sigma_clipped_adc_average.sv */
// channel   direction  handshake                 payload
// sample    in         push / full               raw_sample
// result    out        empty / pop               millivolts, kept_count
// config    in         psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// one sample is taken per cycle while a burst fills the store
// at burst end full rises and stays high through three serial
// divisions (one quotient bit a cycle) and the clipping pass at one sample a cycle
// the clipped mean division and calibration then overlap the next burst
// reset clears the front-end accumulators and control; the sample store has no reset
// a result waits in the output register without holding up the next burst
module sigma_clipped_adc_average
    import scs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [DATA_W-1:0]     raw_sample,
    output logic                  empty,
    input  logic                  pop,
    output logic [MV_W-1:0]       millivolts,
    output logic [KEPT_W-1:0]     kept_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW = DATA_W + CW;
    localparam int QW = 2 * DATA_W + CW;

    logic [COUNT_W-1:0]  sample_count;
    logic [SLOPE_W-1:0]  calib_slope;
    logic [OFFSET_W-1:0] calib_offset;
    front_ctl_t          fctl;
    back_ctl_t           bctl;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [CW-1:0]       job_n;
    logic [SW-1:0]       job_sum;
    logic [QW-1:0]       job_sq;

    scs_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_count (sample_count),
        .calib_slope  (calib_slope),
        .calib_offset (calib_offset)
    );

    scs_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW),
        .AW          (AW),
        .SW          (SW),
        .QW          (QW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .raw_sample   (raw_sample),
        .sample_count (sample_count),
        .fctl         (fctl),
        .bctl         (bctl),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .job_n        (job_n),
        .job_sum      (job_sum),
        .job_sq       (job_sq)
    );

    scs_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW),
        .AW          (AW),
        .SW          (SW),
        .QW          (QW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fctl         (fctl),
        .bctl         (bctl),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .job_n        (job_n),
        .job_sum      (job_sum),
        .job_sq       (job_sq),
        .calib_slope  (calib_slope),
        .calib_offset (calib_offset),
        .empty        (empty),
        .pop          (pop),
        .millivolts   (millivolts),
        .kept_count   (kept_count)
    );

endmodule

/* tb/scs_burst_checker.sv */
`timescale 1ns / 1ps

module scs_burst_checker
    import scs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [DATA_W-1:0]     raw_sample,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [MV_W-1:0]       millivolts,
    input  logic [KEPT_W-1:0]     kept_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    results_due,
    output int                    fail_count
);

    typedef struct packed {
        logic [MV_W-1:0]   mv;
        logic [KEPT_W-1:0] kept;
    } burst_result_t;

    logic [COUNT_W-1:0]  count_reg;
    logic [SLOPE_W-1:0]  slope_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic [DATA_W-1:0] burst_store [MAX_SAMPLES_DEF];
    longint unsigned   sum_s;
    longint unsigned   sum_sq;
    longint unsigned   stored;
    burst_result_t     result_q [$];

    function automatic longint unsigned burst_len();
        longint unsigned c;
        c = count_reg;
        if (c < 1) c = 1;
        if (c > MAX_SAMPLES_DEF) c = MAX_SAMPLES_DEF;
        return c;
    endfunction

    // floor(65536*s^2/n^2) split so nothing overflows
    function automatic longint unsigned sq_mean_q16(longint unsigned s, longint unsigned n);
        longint unsigned q;
        longint unsigned r;
        q = s / n;
        r = s % n;
        return q * q * 65536 + ((2 * q * r * n + r * r) * 65536) / (n * n);
    endfunction

    function automatic burst_result_t clipped_average(longint unsigned n);
        longint unsigned mean_q8;
        longint unsigned var_q16;
        longint unsigned keep_sum;
        longint unsigned keep_n;
        longint unsigned x;
        longint unsigned d;
        longint unsigned m;
        longint unsigned t;
        burst_result_t   r;
        mean_q8  = (sum_s * 256) / n;
        var_q16  = (sum_sq * 65536) / n - sq_mean_q16(sum_s, n);
        keep_sum = 0;
        keep_n   = 0;
        for (longint unsigned i = 0; i < n; i++) begin
            x = longint'(burst_store[i]) * 256;
            d = (x >= mean_q8) ? x - mean_q8 : mean_q8 - x;
            if (d * d <= var_q16) begin
                keep_sum += burst_store[i];
                keep_n++;
            end
        end
        m = (keep_n == 0) ? 0 : (keep_sum * 256) / keep_n;
        t = (longint'(slope_reg) * m + 8388608 + longint'(offset_reg) * 16777216) / 65536
            + 128;
        t = t / 256;
        r.mv   = (t > 65535) ? 16'hFFFF : t[MV_W-1:0];
        r.kept = keep_n[KEPT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        burst_result_t got;
        burst_result_t want;
        if (!rst_n)
        begin
            count_reg   = SAMPLE_COUNT_RST;
            slope_reg   = '0;
            offset_reg  = '0;
            sum_s       = 0;
            sum_sq      = 0;
            stored      = 0;
            result_q.delete();
            results_due = 0;
            fail_count  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SAMPLE_COUNT: count_reg  = pwdata[COUNT_W-1:0];
                    REG_CALIB_SLOPE:  slope_reg  = pwdata[SLOPE_W-1:0];
                    REG_CALIB_OFFSET: offset_reg = pwdata[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                got.mv   = millivolts;
                got.kept = kept_count;
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result transfer mv=%0d kept=%0d",
                             $time, got.mv, got.kept);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.mv !== want.mv)
                    begin
                        $display("%0t: millivolts expected %0d actual %0d",
                                 $time, want.mv, got.mv);
                        fail_count++;
                    end
                    if (got.kept !== want.kept)
                    begin
                        $display("%0t: kept_count expected %0d actual %0d",
                                 $time, want.kept, got.kept);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
            begin
                if (stored >= MAX_SAMPLES_DEF) stored = MAX_SAMPLES_DEF - 1;
                burst_store[stored] = raw_sample;
                sum_s  += raw_sample;
                sum_sq += longint'(raw_sample) * raw_sample;
                stored++;
                if (stored >= burst_len())
                begin
                    result_q.push_back(clipped_average(stored));
                    sum_s  = 0;
                    sum_sq = 0;
                    stored = 0;
                end
            end
            results_due = result_q.size();
        end
    end

endmodule

/* tb/tb_sigma_clipped_adc_average.sv */
`timescale 1ns / 1ps

module tb_sigma_clipped_adc_average;
    import scs_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [DATA_W-1:0]     raw_sample;
    logic                  empty;
    logic                  pop;
    logic [MV_W-1:0]       millivolts;
    logic [KEPT_W-1:0]     kept_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    results_due;
    int                    fail_count;

    int send_idle_pct;
    int pop_stall_pct;
    int hold_off;
    int cluster_base;

    sigma_clipped_adc_average dut (.*);

    scs_burst_checker checker_i (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .raw_sample(raw_sample),
        .empty(empty), .pop(pop), .millivolts(millivolts), .kept_count(kept_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .results_due(results_due),
        .fail_count(fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("sigma_clipped_adc_average verification failed");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            pop <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send(input logic [DATA_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        raw_sample <= x;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // drain results, then let a half-filled burst or late calibration settle
    task automatic go_quiet();
        push <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_config(input int cnt, input int slope, input int offs);
        reg_write(REG_SAMPLE_COUNT, cnt);
        reg_write(REG_CALIB_SLOPE, slope);
        reg_write(REG_CALIB_OFFSET, offs);
    endtask

    function automatic logic [DATA_W-1:0] pick_sample();
        int k;
        int v;
        k = $urandom_range(9);
        if ($urandom_range(7) == 0) cluster_base = $urandom_range(4095);
        if (k < 2) return DATA_W'($urandom_range(4095));
        if (k == 2) return $urandom_range(1) ? 12'hFFF : 12'h000;
        v = cluster_base + $urandom_range(40) - 20;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return DATA_W'(v);
    endfunction

    function automatic int pick_count();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 0;
        if (k < 3) return $urandom_range(40, 13);
        return $urandom_range(12, 1);
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        raw_sample    = '0;
        pop           = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_off      = 0;
        cluster_base  = 2048;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturating calibration, extremes of the data
        set_config(4, 262143, 4095);
        send(12'h000); send(12'hFFF); send(12'h000); send(12'hFFF);
        go_quiet();
        set_config(1, 0, 0);
        send(12'hFFF);
        go_quiet();
        set_config(3, 65536, 17);
        send(12'h800); send(12'h800); send(12'h800);
        go_quiet();
        // zero count acts as one, unknown register ignored
        reg_write(REG_SAMPLE_COUNT, 0);
        reg_write(2'd3, 32'hFFFF_FFFF);
        send(12'h000);
        send(12'h555);
        go_quiet();
        // count lowered below what is already stored
        reg_write(REG_SAMPLE_COUNT, 8);
        send(12'h001); send(12'h7FF); send(12'hAAA); send(12'h123); send(12'hFFE);
        go_quiet();
        reg_write(REG_SAMPLE_COUNT, 3);
        send(12'h3C0);
        go_quiet();

        for (int mode = 0; mode < 4; mode++)
        begin
            send_idle_pct = (mode == 1 || mode == 3) ? 62 : 0;
            pop_stall_pct = (mode == 2) ? 62 : (mode == 3) ? 29 : 0;
            if (mode == 3) send_idle_pct = 29;
            for (int sub = 0; sub < 2; sub++)
            begin
                set_config(pick_count(), ($urandom_range(3) == 0) ? 262143 :
                           $urandom_range(262143), $urandom_range(4095));
                if (mode == 0 && sub == 0) hold_off = 3000;
                for (int i = 0; i < 55; i++)
                begin
                    if (mode == 2 && sub == 1 && i == 25)
                    begin
                        push <= 1'b0;
                        @(posedge clk);
                        while (results_due != 0) @(posedge clk);
                    end
                    send(pick_sample());
                end
                go_quiet();
            end
        end

        // oversized count saturates, then a lowered count ends the part-filled burst
        send_idle_pct = 0;
        pop_stall_pct = 0;
        set_config(8191, $urandom_range(262143), $urandom_range(4095));
        for (int i = 0; i < 6; i++) send(pick_sample());
        go_quiet();
        reg_write(REG_SAMPLE_COUNT, 2);
        send(pick_sample());

        push <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("sigma_clipped_adc_average verification clean");
        else
            $display("sigma_clipped_adc_average verification failed");
        $finish;
    end

endmodule
